/* rtl/msqm_pkg.sv */
package msqm_pkg;

  // sizes of the list table, the node pool and the stored word
  localparam int NUM_LISTS    = 64;
  localparam int POOL_ENTRIES = 1024;
  localparam int VALUE_WIDTH  = 64;

  localparam int ListW = $clog2(NUM_LISTS);
  localparam int NodeW = $clog2(POOL_ENTRIES);
  localparam int CntW  = NodeW + 1;

  // fixed port widths
  localparam int CmdW    = 2;
  localparam int IdW     = 6;
  localparam int StatusW = 3;
  localparam int WordW   = 64;

  typedef enum logic [CmdW-1:0] {
    CMD_CREATE = 2'd0,
    CMD_PUSH   = 2'd1,
    CMD_POP    = 2'd2,
    CMD_POP_ALT = 2'd3
  } cmd_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 3'd0,
    ST_EXISTS  = 3'd1,
    ST_MISSING = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_POP
  } state_t;

  // one entry of the list table
  typedef struct packed {
    logic             is_queue;
    logic             nonempty;
    logic [NodeW-1:0] head;
    logic [NodeW-1:0] tail;
  } lst_t;

  localparam int LstW = $bits(lst_t);

  // requests to the node allocator
  typedef struct packed {
    logic             take;
    logic             give;
    logic [NodeW-1:0] give_node;
  } alloc_req_t;

  // allocator status
  typedef struct packed {
    logic             avail;
    logic [NodeW-1:0] node;
    logic [NodeW-1:0] free_top;
  } alloc_rsp_t;

endpackage

/* rtl/msqm_ram.sv */
module msqm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/msqm_alloc.sv */
module msqm_alloc (
  input  logic                                clk,
  input  logic                                rst_n,
  input  msqm_pkg::alloc_req_t                req,
  input  logic [msqm_pkg::NodeW-1:0]          link_rd,
  output msqm_pkg::alloc_rsp_t                rsp
);

  logic [msqm_pkg::CntW-1:0]  fresh_count_r, fresh_count_nxt;
  logic [msqm_pkg::CntW-1:0]  free_count_r, free_count_nxt;
  logic [msqm_pkg::NodeW-1:0] free_top_r, free_top_nxt;
  logic                       free_nonempty_r, free_nonempty_nxt;

  // freed nodes first, then never used nodes in order
  always_comb begin
    rsp.free_top = free_top_r;
    rsp.avail    = free_nonempty_r ||
                   (fresh_count_r < msqm_pkg::CntW'(msqm_pkg::POOL_ENTRIES));
    rsp.node     = free_nonempty_r ? free_top_r
                                   : fresh_count_r[msqm_pkg::NodeW-1:0];
  end

  // free list update on take or give
  always_comb begin
    fresh_count_nxt   = fresh_count_r;
    free_count_nxt    = free_count_r;
    free_top_nxt      = free_top_r;
    free_nonempty_nxt = free_nonempty_r;
    if (req.take) begin
      if (free_nonempty_r) begin
        free_count_nxt = free_count_r - 1'b1;
        if (free_count_r == msqm_pkg::CntW'(1)) begin
          free_nonempty_nxt = 1'b0;
        end else begin
          free_top_nxt = link_rd;
        end
      end else begin
        fresh_count_nxt = fresh_count_r + 1'b1;
      end
    end else if (req.give) begin
      free_top_nxt      = req.give_node;
      free_nonempty_nxt = 1'b1;
      free_count_nxt    = free_count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_count_r   <= '0;
      free_count_r    <= '0;
      free_top_r      <= '0;
      free_nonempty_r <= 1'b0;
    end else begin
      fresh_count_r   <= fresh_count_nxt;
      free_count_r    <= free_count_nxt;
      free_top_r      <= free_top_nxt;
      free_nonempty_r <= free_nonempty_nxt;
    end
  end

endmodule

/* rtl/multi_stack_queue_manager.sv */
// create and push give their registered result from the look state, pop from the pop state after it
// a new command is taken only in the idle state; busy is high while a command is in progress
// the look and pop states wait on the registered read of the list table and node memories
// synchronous active-low reset clears the list-exists flags, allocator and sequencer
// memory contents are not cleared; the receiver cannot stall, each result is a one-cycle strobe
module multi_stack_queue_manager (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [msqm_pkg::CmdW-1:0]        in_command,
  input  logic [msqm_pkg::IdW-1:0]         in_list_id,
  input  logic                             in_list_kind,
  input  logic [msqm_pkg::WordW-1:0]       in_push_value,
  output logic                             out_valid,
  output logic [msqm_pkg::StatusW-1:0]     out_status,
  output logic                             out_value_valid,
  output logic [msqm_pkg::WordW-1:0]       out_popped_value
);

  localparam int NodeW = msqm_pkg::NodeW;
  localparam int ListW = msqm_pkg::ListW;
  localparam int ValW  = msqm_pkg::VALUE_WIDTH;

  msqm_pkg::state_t state_r, state_nxt;

  // captured transaction
  msqm_pkg::cmd_t          cmd_r;
  logic [msqm_pkg::IdW-1:0] id_r;
  logic                    kind_r;
  logic [ValW-1:0]         val_r;

  logic [msqm_pkg::NUM_LISTS-1:0] exists_r, exists_nxt;

  // result registers
  logic                         out_valid_r, out_valid_nxt;
  msqm_pkg::status_t            status_r, status_nxt;
  logic                         value_valid_r, value_valid_nxt;
  logic [msqm_pkg::WordW-1:0]   popped_r, popped_nxt;

  // memory ports
  logic                  lst_we;
  logic [ListW-1:0]      lst_raddr;
  msqm_pkg::lst_t        lst_wdata, lst_rd;
  logic [msqm_pkg::LstW-1:0] lst_rdata;
  logic                  link_we;
  logic [NodeW-1:0]      link_waddr, link_wdata, link_raddr, link_rd;
  logic                  val_we;
  logic [NodeW-1:0]      val_waddr;
  logic [ValW-1:0]       val_rd;

  msqm_pkg::alloc_req_t  alloc_req;
  msqm_pkg::alloc_rsp_t  alloc_rsp;

  logic [ListW-1:0]      lidx;
  logic                  id_oob;
  logic                  lst_exists;
  logic                  accept;

  assign accept     = start && (state_r == msqm_pkg::S_IDLE);
  assign busy       = (state_r != msqm_pkg::S_IDLE);
  assign lidx       = id_r[ListW-1:0];
  assign id_oob     = {1'b0, id_r} >= (msqm_pkg::IdW+1)'(msqm_pkg::NUM_LISTS);
  assign lst_exists = exists_r[lidx];
  assign lst_rd     = msqm_pkg::lst_t'(lst_rdata);

  // read addresses: list entry and free-list top while idle, head node afterwards
  assign lst_raddr  = (state_r == msqm_pkg::S_IDLE) ? in_list_id[ListW-1:0] : lidx;
  assign link_raddr = (state_r == msqm_pkg::S_IDLE) ? alloc_rsp.free_top : lst_rd.head;

  msqm_ram #(.WIDTH(msqm_pkg::LstW), .DEPTH(msqm_pkg::NUM_LISTS)) u_lst_ram (
    .clk   (clk),
    .we    (lst_we),
    .waddr (lidx),
    .wdata (lst_wdata),
    .raddr (lst_raddr),
    .rdata (lst_rdata)
  );

  msqm_ram #(.WIDTH(NodeW), .DEPTH(msqm_pkg::POOL_ENTRIES)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rd)
  );

  msqm_ram #(.WIDTH(ValW), .DEPTH(msqm_pkg::POOL_ENTRIES)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_r),
    .raddr (lst_rd.head),
    .rdata (val_rd)
  );

  msqm_alloc u_alloc (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (alloc_req),
    .link_rd (link_rd),
    .rsp     (alloc_rsp)
  );

  // sequencer: decide in the look state, finish a pop in the pop state that follows it
  always_comb begin
    state_nxt       = state_r;
    exists_nxt      = exists_r;
    out_valid_nxt   = 1'b0;
    status_nxt      = msqm_pkg::ST_OK;
    value_valid_nxt = 1'b0;
    popped_nxt      = '0;
    lst_we          = 1'b0;
    lst_wdata       = lst_rd;
    link_we         = 1'b0;
    link_waddr      = alloc_rsp.node;
    link_wdata      = lst_rd.head;
    val_we          = 1'b0;
    val_waddr       = alloc_rsp.node;
    alloc_req       = '0;
    case (state_r)
      msqm_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = msqm_pkg::S_LOOK;
        end
      end
      msqm_pkg::S_LOOK: begin
        state_nxt     = msqm_pkg::S_IDLE;
        out_valid_nxt = 1'b1;
        case (cmd_r)
          msqm_pkg::CMD_CREATE: begin
            if (id_oob) begin
              status_nxt = msqm_pkg::ST_MISSING;
            end else if (lst_exists) begin
              status_nxt = msqm_pkg::ST_EXISTS;
            end else begin
              exists_nxt[lidx]   = 1'b1;
              lst_we             = 1'b1;
              lst_wdata.is_queue = kind_r;
              lst_wdata.nonempty = 1'b0;
            end
          end
          msqm_pkg::CMD_PUSH: begin
            if (id_oob || !lst_exists) begin
              status_nxt = msqm_pkg::ST_MISSING;
            end else if (!alloc_rsp.avail) begin
              status_nxt = msqm_pkg::ST_FULL;
            end else begin
              alloc_req.take     = 1'b1;
              val_we             = 1'b1;
              lst_we             = 1'b1;
              lst_wdata.nonempty = 1'b1;
              if (!lst_rd.nonempty) begin
                lst_wdata.head = alloc_rsp.node;
                lst_wdata.tail = alloc_rsp.node;
              end else if (lst_rd.is_queue) begin
                // queue: link old tail to the new node
                link_we        = 1'b1;
                link_waddr     = lst_rd.tail;
                link_wdata     = alloc_rsp.node;
                lst_wdata.tail = alloc_rsp.node;
              end else begin
                // stack: new node points at the old head
                link_we        = 1'b1;
                link_waddr     = alloc_rsp.node;
                link_wdata     = lst_rd.head;
                lst_wdata.head = alloc_rsp.node;
              end
            end
          end
          default: begin
            if (id_oob || !lst_exists) begin
              status_nxt = msqm_pkg::ST_MISSING;
            end else if (!lst_rd.nonempty) begin
              status_nxt = msqm_pkg::ST_EMPTY;
            end else begin
              out_valid_nxt = 1'b0;
              state_nxt     = msqm_pkg::S_POP;
            end
          end
        endcase
      end
      msqm_pkg::S_POP: begin
        state_nxt       = msqm_pkg::S_IDLE;
        out_valid_nxt   = 1'b1;
        value_valid_nxt = 1'b1;
        popped_nxt      = msqm_pkg::WordW'(val_rd);
        lst_we          = 1'b1;
        if (lst_rd.head == lst_rd.tail) begin
          lst_wdata.nonempty = 1'b0;
        end else begin
          lst_wdata.head = link_rd;
        end
        // return the head node to the free list
        link_we             = 1'b1;
        link_waddr          = lst_rd.head;
        link_wdata          = alloc_rsp.free_top;
        alloc_req.give      = 1'b1;
        alloc_req.give_node = lst_rd.head;
      end
      default: begin
        state_nxt = msqm_pkg::S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= msqm_pkg::S_IDLE;
      exists_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      exists_r    <= exists_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // transaction capture and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= msqm_pkg::cmd_t'(in_command);
      id_r   <= in_list_id;
      kind_r <= in_list_kind;
      val_r  <= in_push_value[ValW-1:0];
    end
    status_r      <= status_nxt;
    value_valid_r <= value_valid_nxt;
    popped_r      <= popped_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_value_valid  = value_valid_r;
  assign out_popped_value = popped_r;

endmodule

/* rtl/msqm_checker.sv */
module msqm_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic [msqm_pkg::StatusW-1:0]  out_status,
  input logic                          out_value_valid,
  input logic [msqm_pkg::WordW-1:0]    out_popped_value
);

  // an accepted transaction makes the block busy
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted transaction");

  // no result in the cycle right after a transaction is taken
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_valid)
    else $error("result too early");

  // a result ends the busy period
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result while still busy");

  // a returned value only comes with an ok status
  a_value_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_value_valid |-> (out_valid && out_status == msqm_pkg::ST_OK))
    else $error("value returned without ok status");

  // no value returned means the word is zero
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_value_valid) |-> (out_popped_value == '0))
    else $error("popped value not zero");

endmodule

bind multi_stack_queue_manager msqm_checker u_msqm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_status       (out_status),
  .out_value_valid  (out_value_valid),
  .out_popped_value (out_popped_value)
);

/* tb/multi_stack_queue_manager_tb.sv */
module multi_stack_queue_manager_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import msqm_pkg::*;

  localparam int IdleLimit = 1000;
  localparam int DrainCycles = 8;

  // one command with its expected result, where that can be typed in
  typedef struct packed {
    cmd_t             cmd;
    logic [IdW-1:0]   id;
    logic             kind;
    logic [WordW-1:0] word;
    logic             typed;
    status_t          status;
    logic             vv;
    logic [WordW-1:0] popped;
  } step_row_t;

  typedef struct packed {
    status_t          status;
    logic             vv;
    logic [WordW-1:0] popped;
  } list_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [CmdW-1:0] in_command = '0;
  logic [IdW-1:0] in_list_id = '0;
  logic in_list_kind = 1'b0;
  logic [WordW-1:0] in_push_value = '0;
  logic out_valid;
  logic [StatusW-1:0] out_status;
  logic out_value_valid;
  logic [WordW-1:0] out_popped_value;

  // typed expectation travelling with the command being offered
  logic tag_typed = 1'b0;
  status_t tag_status = ST_OK;
  logic tag_vv = 1'b0;
  logic [WordW-1:0] tag_popped = '0;

  multi_stack_queue_manager dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_list_id       (in_list_id),
    .in_list_kind     (in_list_kind),
    .in_push_value    (in_push_value),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_value_valid  (out_value_valid),
    .out_popped_value (out_popped_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the list table, node pool and free list
  logic             list_live   [NUM_LISTS];
  logic             list_fifo   [NUM_LISTS];
  logic             list_filled [NUM_LISTS];
  logic [NodeW-1:0] list_first  [NUM_LISTS];
  logic [NodeW-1:0] list_last   [NUM_LISTS];
  logic [WordW-1:0] pool_word   [POOL_ENTRIES];
  logic [NodeW-1:0] pool_next   [POOL_ENTRIES];
  int               fresh_next = 0;
  logic [NodeW-1:0] spare_top = '0;
  logic             spare_any = 1'b0;
  int               spare_count = 0;

  list_result_t expected_results[$];
  int fault_count = 0;
  int full_seen = 0;
  int idle_cycles = 0;
  int sent_count = 0;

  localparam logic [WordW-1:0] WordMask = {WordW{1'b1}} >> (WordW - VALUE_WIDTH);

  initial begin
    for (int i = 0; i < NUM_LISTS; i++) begin
      list_live[i] = 1'b0;
      list_fifo[i] = 1'b0;
      list_filled[i] = 1'b0;
      list_first[i] = '0;
      list_last[i] = '0;
    end
    for (int i = 0; i < POOL_ENTRIES; i++) begin
      pool_word[i] = '0;
      pool_next[i] = '0;
    end
  end

  // apply one command to the shadow state and work out its result
  task automatic model_command(input logic [CmdW-1:0] cmd, input logic [IdW-1:0] id,
                               input logic kind, input logic [WordW-1:0] word,
                               output list_result_t res);
    logic [NodeW-1:0] n;
    logic got;
    int l;
    res.status = ST_OK;
    res.vv = 1'b0;
    res.popped = '0;
    l = int'(id);
    got = 1'b1;
    n = '0;
    if (l >= NUM_LISTS) begin
      res.status = ST_MISSING;
    end else if (cmd == CMD_CREATE) begin
      if (list_live[l]) begin
        res.status = ST_EXISTS;
      end else begin
        list_live[l] = 1'b1;
        list_fifo[l] = kind;
        list_filled[l] = 1'b0;
      end
    end else if (!list_live[l]) begin
      res.status = ST_MISSING;
    end else if (cmd == CMD_PUSH) begin
      // free list first, then never-used nodes in order
      if (spare_any) begin
        n = spare_top;
        spare_count--;
        if (spare_count == 0) spare_any = 1'b0;
        else spare_top = pool_next[n];
      end else if (fresh_next < POOL_ENTRIES) begin
        n = NodeW'(fresh_next);
        fresh_next++;
      end else begin
        got = 1'b0;
      end
      if (!got) begin
        res.status = ST_FULL;
        full_seen++;
      end else begin
        pool_word[n] = word & WordMask;
        if (!list_filled[l]) begin
          list_first[l] = n;
          list_last[l] = n;
          list_filled[l] = 1'b1;
        end else if (list_fifo[l]) begin
          pool_next[list_last[l]] = n;
          list_last[l] = n;
        end else begin
          pool_next[n] = list_first[l];
          list_first[l] = n;
        end
      end
    end else begin
      // pop, both encodings
      if (!list_filled[l]) begin
        res.status = ST_EMPTY;
      end else begin
        n = list_first[l];
        res.popped = pool_word[n];
        res.vv = 1'b1;
        if (n == list_last[l]) list_filled[l] = 1'b0;
        else list_first[l] = pool_next[n];
        pool_next[n] = spare_top;
        spare_top = n;
        spare_any = 1'b1;
        spare_count++;
      end
    end
  endtask

  // result check first, then record the transaction accepted at this edge
  always @(posedge clk) begin
    list_result_t exp_res;
    list_result_t pred_res;
    if (rst_n) begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: status %0d value_valid %0d popped_value %h",
                 out_status, out_value_valid, out_popped_value);
          fault_count++;
        end else begin
          exp_res = expected_results.pop_front();
          if (out_status !== exp_res.status) begin
            $error("status: expected %0d, actual %0d", exp_res.status, out_status);
            fault_count++;
          end
          if (out_value_valid !== exp_res.vv) begin
            $error("value_valid: expected %0d, actual %0d", exp_res.vv, out_value_valid);
            fault_count++;
          end
          if (out_popped_value !== exp_res.popped) begin
            $error("popped_value: expected %h, actual %h", exp_res.popped, out_popped_value);
            fault_count++;
          end
        end
      end
      if (start && !busy) begin
        model_command(in_command, in_list_id, in_list_kind, in_push_value, pred_res);
        if (tag_typed) begin
          exp_res.status = tag_status;
          exp_res.vv = tag_vv;
          exp_res.popped = tag_popped;
          expected_results.push_back(exp_res);
        end else begin
          expected_results.push_back(pred_res);
        end
      end
      if (out_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    while (idle_cycles < IdleLimit) @(posedge clk);
    $display("multi_stack_queue_manager regression: fail");
    $finish;
  end

  // offer one command after a random gap and hold it until accepted
  task automatic send_command(input logic [CmdW-1:0] cmd, input logic [IdW-1:0] id,
                              input logic kind, input logic [WordW-1:0] word,
                              input logic typed, input status_t st, input logic vv,
                              input logic [WordW-1:0] popped);
    int gap;
    gap = (sent_count % 64 < 16) ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_command <= cmd;
    in_list_id <= id;
    in_list_kind <= kind;
    in_push_value <= word;
    tag_typed <= typed;
    tag_status <= st;
    tag_vv <= vv;
    tag_popped <= popped;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_count++;
  endtask

  // mostly an existing list, otherwise any index
  function automatic logic [IdW-1:0] pick_list_id();
    logic [IdW-1:0] id;
    id = IdW'($urandom_range(0, 63));
    if ($urandom_range(0, 99) < 85) begin
      for (int t = 0; t < 16; t++) begin
        if (list_live[id]) break;
        id = IdW'($urandom_range(0, 63));
      end
    end
    return id;
  endfunction

  task automatic random_command(input int create_pct, input int push_pct);
    logic [CmdW-1:0] cmd;
    logic [IdW-1:0] id;
    logic kind;
    logic [WordW-1:0] word;
    int r;
    r = $urandom_range(0, 99);
    kind = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 15))
      0: word = '0;
      1: word = '1;
      default: word = {$urandom, $urandom};
    endcase
    if ($urandom_range(0, 19) == 0) begin
      // noise: any command, any index
      cmd = CmdW'($urandom_range(0, 3));
      id = IdW'($urandom_range(0, 63));
    end else if (r < create_pct) begin
      cmd = CMD_CREATE;
      id = IdW'($urandom_range(0, 63));
    end else if (r < create_pct + push_pct) begin
      cmd = CMD_PUSH;
      id = pick_list_id();
    end else begin
      cmd = ($urandom_range(0, 4) == 0) ? CMD_POP_ALT : CMD_POP;
      id = pick_list_id();
    end
    send_command(cmd, id, kind, word, 1'b0, ST_OK, 1'b0, '0);
  endtask

  // directed commands: errors, both list kinds, the alternate pop code, extremes
  step_row_t directed_rows [0:24] = '{
    '{CMD_POP,     6'd0,  1'b0, 64'd0,                 1'b1, ST_MISSING, 1'b0, 64'd0},
    '{CMD_PUSH,    6'd63, 1'b1, 64'hffffffffffffffff,  1'b1, ST_MISSING, 1'b0, 64'd0},
    '{CMD_CREATE,  6'd0,  1'b0, 64'd0,                 1'b1, ST_OK,      1'b0, 64'd0},
    '{CMD_CREATE,  6'd0,  1'b1, 64'd0,                 1'b1, ST_EXISTS,  1'b0, 64'd0},
    '{CMD_POP,     6'd0,  1'b0, 64'd0,                 1'b1, ST_EMPTY,   1'b0, 64'd0},
    '{CMD_PUSH,    6'd0,  1'b0, 64'd0,                 1'b1, ST_OK,      1'b0, 64'd0},
    '{CMD_PUSH,    6'd0,  1'b0, 64'hffffffffffffffff,  1'b1, ST_OK,      1'b0, 64'd0},
    '{CMD_POP,     6'd0,  1'b0, 64'd0,                 1'b1, ST_OK,      1'b1,
      64'hffffffffffffffff},
    '{CMD_POP_ALT, 6'd0,  1'b0, 64'd0,                 1'b1, ST_OK,      1'b1, 64'd0},
    '{CMD_POP,     6'd0,  1'b0, 64'd0,                 1'b1, ST_EMPTY,   1'b0, 64'd0},
    '{CMD_CREATE,  6'd63, 1'b1, 64'd0,                 1'b1, ST_OK,      1'b0, 64'd0},
    '{CMD_PUSH,    6'd63, 1'b0, 64'h0123456789abcdef,  1'b0, ST_OK,      1'b0, 64'd0},
    '{CMD_PUSH,    6'd63, 1'b1, 64'hfedcba9876543210,  1'b0, ST_OK,      1'b0, 64'd0},
    '{CMD_PUSH,    6'd63, 1'b0, 64'h8000000000000001,  1'b0, ST_OK,      1'b0, 64'd0},
    '{CMD_POP,     6'd63, 1'b1, 64'd0,                 1'b0, ST_OK,      1'b0, 64'd0},
    '{CMD_POP_ALT, 6'd63, 1'b0, 64'd0,                 1'b0, ST_OK,      1'b0, 64'd0},
    '{CMD_PUSH,    6'd63, 1'b1, 64'h5555555555555555,  1'b0, ST_OK,      1'b0, 64'd0},
    '{CMD_POP,     6'd63, 1'b0, 64'd0,                 1'b0, ST_OK,      1'b0, 64'd0},
    '{CMD_POP,     6'd63, 1'b0, 64'd0,                 1'b0, ST_OK,      1'b0, 64'd0},
    '{CMD_POP,     6'd63, 1'b1, 64'd0,                 1'b1, ST_EMPTY,   1'b0, 64'd0},
    '{CMD_PUSH,    6'd63, 1'b0, 64'haaaaaaaaaaaaaaaa,  1'b0, ST_OK,      1'b0, 64'd0},
    '{CMD_POP,     6'd63, 1'b0, 64'd0,                 1'b0, ST_OK,      1'b0, 64'd0},
    '{CMD_CREATE,  6'd32, 1'b0, 64'hffffffffffffffff,  1'b1, ST_OK,      1'b0, 64'd0},
    '{CMD_POP_ALT, 6'd5,  1'b1, 64'd0,                 1'b1, ST_MISSING, 1'b0, 64'd0},
    '{CMD_PUSH,    6'd32, 1'b1, 64'h00000000ffffffff,  1'b0, ST_OK,      1'b0, 64'd0}
  };

  // main sequence
  initial begin
    int n;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_command(directed_rows[i].cmd, directed_rows[i].id, directed_rows[i].kind,
                   directed_rows[i].word, directed_rows[i].typed, directed_rows[i].status,
                   directed_rows[i].vv, directed_rows[i].popped);
    end

    // balanced mix with free-list reuse
    for (int i = 0; i < 150; i++) random_command(12, 48);

    // push-heavy until the pool has run out 24 times or 3000 commands have been sent
    n = 0;
    while (full_seen < 24 && n < 3000) begin
      random_command(3, 90);
      n++;
    end

    // pop-heavy drain
    for (int i = 0; i < 250; i++) random_command(5, 15);

    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (fault_count == 0 && expected_results.size() == 0) begin
      $display("multi_stack_queue_manager regression: pass");
    end else begin
      $display("multi_stack_queue_manager regression: fail");
    end
    $finish;
  end

endmodule
